// ===== src/crcfr_pkg.sv =====
`timescale 1ns / 1ps

package crcfr_pkg;

   // Result codes carried in the kind field
   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_GOOD     = 2'd1,
      KIND_CRC_ERR  = 2'd2,
      KIND_OVERSIZE = 2'd3
   } kind_type;

   // Register indexes on the csr port
   typedef enum logic {
      CSR_SYNC_BYTE   = 1'b0,
      CSR_MAX_PAYLOAD = 1'b1
   } csr_index_type;

   localparam int CSR_DATA_W = 16;

   localparam logic [7:0]  SYNC_BYTE_RESET   = 8'hA5;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd512;
   localparam logic [7:0]  CRC_POLY          = 8'h07;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  command;
      logic [7:0]  data;
      logic [15:0] frame_length;
   } result_type;

   // CRC-8/SMBUS, one byte, MSB first
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== src/crc8_frame_receiver.sv =====
`timescale 1ns / 1ps

// Command-frame receiver with CRC-8 (poly 0x07, init 0) check.
// Input channel: one received byte per transaction on req_rx_byte, taken
//   at a clock edge with req_push high and req_full low.
// The front hunts for the sync byte, then takes command, 16-bit LE length,
//   payload and CRC. Every payload byte gives a result (kind 0); the CRC
//   byte gives frame good (1) or CRC error (2); a length above max_payload
//   drops the first byte after the header and gives kind 3 (data 0).
// Result channel: oldest result on rsp_* while rsp_empty is low, taken at
//   an edge with rsp_pop high. Results sit in a FIFO_DEPTH-entry queue.
// A result is visible in the cycle after its byte is accepted.
// Throughput: one byte per cycle while req_full is low; the front does the
//   whole update (state, length compare and an unrolled CRC byte step) per byte.
// If the receiver stalls, the queue fills and req_full rises; input then
//   waits until a result is popped. req_full covers bytes with no result too.
// csr port: index 0 sync_byte, index 1 max_payload; writes take effect on
//   the next byte.
// Reset (synchronous): hunting, queue empty, sync 0xA5, max_payload 512.
module crc8_frame_receiver #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_command,
   output logic [7:0]  rsp_data,
   output logic [15:0] rsp_frame_length,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic                  accept;
   logic                  front_valid;
   crcfr_pkg::result_type front_result;
   crcfr_pkg::result_type head;

   // a byte is taken only when the queue has room
   assign accept = req_push & ~req_full;

   crcfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_byte    (req_rx_byte),
      .csr_we     (csr_we),
      .csr_index  (crcfr_pkg::csr_index_type'(csr_index)),
      .csr_wdata  (csr_wdata),
      .out_valid  (front_valid),
      .out_result (front_result)
   );

   crcfr_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_result),
      .pop       (rsp_pop),
      .pop_data  (head),
      .empty     (rsp_empty),
      .full      (req_full)
   );

   assign rsp_kind         = head.kind;
   assign rsp_command      = head.command;
   assign rsp_data         = head.data;
   assign rsp_frame_length = head.frame_length;

endmodule

// ===== src/crcfr_front.sv =====
`timescale 1ns / 1ps

module crcfr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [7:0]                    in_byte,
   input  logic                          csr_we,
   input  crcfr_pkg::csr_index_type      csr_index,
   input  logic [crcfr_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                          out_valid,
   output crcfr_pkg::result_type         out_result
);

   typedef enum logic [1:0] {
      ST_HUNT = 2'd0,
      ST_CMD  = 2'd1,
      ST_LEN  = 2'd2,
      ST_BODY = 2'd3
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  command_ff, command_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  sync_ff;
   logic [15:0] max_ff;
   logic [7:0]  crc_next;

   // one CRC step shared by every phase that folds the byte in
   assign crc_next = crcfr_pkg::crc8_update((state_ff == ST_CMD) ? 8'h00 : crc_ff, in_byte);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      command_in = command_ff;
      length_in  = length_ff;
      crc_in     = crc_ff;
      out_valid  = 1'b0;
      out_result.kind         = crcfr_pkg::KIND_PAYLOAD;
      out_result.command      = command_ff;
      out_result.data         = in_byte;
      out_result.frame_length = length_ff;
      if (in_valid) begin
         unique case (state_ff)
            ST_HUNT: begin
               if (in_byte == sync_ff) begin
                  state_in = ST_CMD;
                  count_in = 16'd0;
                  crc_in   = 8'h00;
               end
            end
            ST_CMD: begin
               command_in = in_byte;
               crc_in     = crc_next;
               count_in   = 16'd0;
               state_in   = ST_LEN;
            end
            ST_LEN: begin
               crc_in = crc_next;
               if (count_ff == 16'd0) begin
                  length_in = {8'h00, in_byte};
                  count_in  = 16'd1;
               end else begin
                  length_in = {in_byte, length_ff[7:0]};
                  count_in  = 16'd0;
                  state_in  = ST_BODY;
               end
            end
            ST_BODY: begin
               out_valid = 1'b1;
               priority if (length_ff > max_ff) begin
                  state_in        = ST_HUNT;
                  count_in        = 16'd0;
                  out_result.kind = crcfr_pkg::KIND_OVERSIZE;
                  out_result.data = 8'h00;
               end else if (count_ff < length_ff) begin
                  crc_in   = crc_next;
                  count_in = count_ff + 16'd1;
               end else begin
                  state_in        = ST_HUNT;
                  count_in        = 16'd0;
                  out_result.kind = (crc_ff == in_byte) ? crcfr_pkg::KIND_GOOD
                                                        : crcfr_pkg::KIND_CRC_ERR;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_HUNT;
         count_ff   <= 16'd0;
         command_ff <= 8'h00;
         length_ff  <= 16'd0;
         crc_ff     <= 8'h00;
         sync_ff    <= crcfr_pkg::SYNC_BYTE_RESET;
         max_ff     <= crcfr_pkg::MAX_PAYLOAD_RESET;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         crc_ff     <= crc_in;
         if (csr_we) begin
            unique case (csr_index)
               crcfr_pkg::CSR_SYNC_BYTE:   sync_ff <= csr_wdata[7:0];
               crcfr_pkg::CSR_MAX_PAYLOAD: max_ff  <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== src/crcfr_fifo.sv =====
`timescale 1ns / 1ps

module crcfr_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  crcfr_pkg::result_type push_data,
   input  logic                  pop,
   output crcfr_pkg::result_type pop_data,
   output logic                  empty,
   output logic                  full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   crcfr_pkg::result_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign empty    = (count_ff == CNT_W'(0));
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (do_pop)  rd_ptr_ff <= next_ptr(rd_ptr_ff);
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

// ===== src/crcfr_checker.sv =====
`timescale 1ns / 1ps

module crcfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_command,
   input logic [7:0]  rsp_data,
   input logic [15:0] rsp_frame_length
);

   // queue comes up empty
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // no transaction in, nothing shows up
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      (rsp_empty && !(req_push && !req_full)) |=> rsp_empty)
      else $error("result appeared without an input transaction");

   // a waiting result holds until popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_kind) &&
         $stable(rsp_command) && $stable(rsp_data) && $stable(rsp_frame_length)))
      else $error("waiting result changed before pop");

   // full clears only through a pop
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (req_full && !(rsp_pop && !rsp_empty)) |=> req_full)
      else $error("full dropped without a pop");

   // oversize drops carry zero data
   a_oversize_data: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == crcfr_pkg::KIND_OVERSIZE) |-> (rsp_data == 8'h00))
      else $error("oversize result with nonzero data");

endmodule

bind crc8_frame_receiver crcfr_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_push         (req_push),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_kind         (rsp_kind),
   .rsp_command      (rsp_command),
   .rsp_data         (rsp_data),
   .rsp_frame_length (rsp_frame_length)
);

// ===== test/crc8_frame_checker.sv =====
`timescale 1ns / 1ps

package frame_crc_pkg;

   // CRC-8, poly 0x07, MSB first, worked one message bit at a time
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] acc;
      logic       fb;
      acc = crc;
      for (int i = 7; i >= 0; i--) begin
         fb  = acc[7] ^ b[i];
         acc = {acc[6:0], 1'b0} ^ (fb ? crcfr_pkg::CRC_POLY : 8'h00);
      end
      return acc;
   endfunction

endpackage

module crc8_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [1:0]  rsp_kind,
   input  logic [7:0]  rsp_command,
   input  logic [7:0]  rsp_data,
   input  logic [15:0] rsp_frame_length,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   output int          error_count,
   output int          pending_count,
   output int          results_checked
);

   typedef enum logic [1:0] {
      SEEK_SYNC = 2'd0,
      TAKE_CMD  = 2'd1,
      TAKE_LEN  = 2'd2,
      TAKE_BODY = 2'd3
   } rx_phase_type;

   logic [7:0]  cfg_sync;
   logic [15:0] cfg_max_len;

   rx_phase_type rx_phase;
   logic [15:0]  rx_count;
   logic [7:0]   rx_cmd;
   logic [15:0]  rx_len;
   logic [7:0]   rx_crc;

   crcfr_pkg::result_type deframed_q[$];

   // Advance the deframer by one received byte; queue the result it gives, if any.
   task automatic deframe_byte(input logic [7:0] b);
      crcfr_pkg::result_type r;
      r.command      = rx_cmd;
      r.frame_length = rx_len;
      case (rx_phase)
         SEEK_SYNC: begin
            if (b == cfg_sync) begin
               rx_phase = TAKE_CMD;
               rx_count = 16'd0;
               rx_crc   = 8'h00;
            end
         end
         TAKE_CMD: begin
            rx_cmd   = b;
            rx_crc   = frame_crc_pkg::crc8_next(8'h00, b);
            rx_count = 16'd0;
            rx_phase = TAKE_LEN;
         end
         TAKE_LEN: begin
            rx_crc = frame_crc_pkg::crc8_next(rx_crc, b);
            if (rx_count == 16'd0) begin
               rx_len   = {8'h00, b};
               rx_count = 16'd1;
            end else begin
               rx_len[15:8] = b;
               rx_count     = 16'd0;
               rx_phase     = TAKE_BODY;
            end
         end
         default: begin
            if (rx_len > cfg_max_len) begin
               r.kind   = crcfr_pkg::KIND_OVERSIZE;
               r.data   = 8'h00;
               rx_phase = SEEK_SYNC;
               rx_count = 16'd0;
            end else if (rx_count < rx_len) begin
               rx_crc   = frame_crc_pkg::crc8_next(rx_crc, b);
               rx_count = rx_count + 16'd1;
               r.kind   = crcfr_pkg::KIND_PAYLOAD;
               r.data   = b;
            end else begin
               r.kind   = (rx_crc == b) ? crcfr_pkg::KIND_GOOD : crcfr_pkg::KIND_CRC_ERR;
               r.data   = b;
               rx_phase = SEEK_SYNC;
               rx_count = 16'd0;
            end
            deframed_q.push_back(r);
         end
      endcase
   endtask

   always @(posedge clock) begin
      crcfr_pkg::result_type want;
      if (reset) begin
         cfg_sync    = crcfr_pkg::SYNC_BYTE_RESET;
         cfg_max_len = crcfr_pkg::MAX_PAYLOAD_RESET;
         rx_phase    = SEEK_SYNC;
         rx_count    = 16'd0;
         rx_cmd      = 8'h00;
         rx_len      = 16'd0;
         rx_crc      = 8'h00;
         deframed_q.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_checked++;
            if (deframed_q.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: unexpected result kind %0d cmd %h data %h len %0d",
                           $time, rsp_kind, rsp_command, rsp_data, rsp_frame_length);
            end else begin
               want = deframed_q.pop_front();
               if (rsp_kind !== want.kind || rsp_command !== want.command ||
                   rsp_data !== want.data || rsp_frame_length !== want.frame_length) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("%0t: expected kind %0d cmd %h data %h len %0d, got %0d %h %h %0d",
                              $time, want.kind, want.command, want.data, want.frame_length,
                              rsp_kind, rsp_command, rsp_data, rsp_frame_length);
               end
            end
         end
         if (req_push && !req_full)
            deframe_byte(req_rx_byte);
         // register writes count from the next byte on
         if (csr_we) begin
            if (csr_index == crcfr_pkg::CSR_SYNC_BYTE)
               cfg_sync = csr_wdata[7:0];
            else
               cfg_max_len = csr_wdata;
         end
      end
      pending_count = deframed_q.size();
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// Top of the frame receiver bench. Drives a byte stream into the block and
// drains its result queue; crc8_frame_checker sits beside the block, follows
// every transaction on both channels and the register port, and reports a
// failure count back here. This module only makes stimulus and decides.
module tb;

   localparam int QUIET_LIMIT   = 4000; // cycles without any transaction -> timeout
   localparam int HOLD_CYCLES   = 120;  // long receiver hold-off, fills the result queue
   localparam int PHASE_ITEMS   = 125;  // random bytes per register setting
   localparam int RANDOM_PHASES = 8;
   localparam int SETTLE_CYCLES = 4;    // result shows in the cycle after its byte

   // receiver stall patterns
   localparam int SINK_ALWAYS       = 0;
   localparam int SINK_COIN         = 1;
   localparam int SINK_EVERY_FOURTH = 2;
   localparam int SINK_SPARSE       = 3;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_push    = 1'b0;
   logic        req_full;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop     = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_command;
   logic [7:0]  rsp_data;
   logic [15:0] rsp_frame_length;
   logic        csr_we      = 1'b0;
   logic        csr_index   = 1'b0;
   logic [15:0] csr_wdata   = 16'h0000;

   int error_count;
   int pending_count;
   int results_checked;

   // sender bookkeeping
   int          burst_left;
   int          bytes_sent;
   int          frames_sent;
   int          oversize_frames;
   int          bad_crc_frames;
   int          settings_used;
   int          full_stalls;
   int          long_holds;
   int          quiet_cycles;
   bit          hold_request;
   logic [7:0]  tx_crc;
   logic [7:0]  cur_sync = crcfr_pkg::SYNC_BYTE_RESET;   // mirror, for shaping stimulus only
   logic [15:0] cur_max  = crcfr_pkg::MAX_PAYLOAD_RESET;

   always #2 clock = ~clock;

   crc8_frame_receiver uut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_rx_byte      (req_rx_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_kind         (rsp_kind),
      .rsp_command      (rsp_command),
      .rsp_data         (rsp_data),
      .rsp_frame_length (rsp_frame_length),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   crc8_frame_checker chk (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_rx_byte      (req_rx_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_kind         (rsp_kind),
      .rsp_command      (rsp_command),
      .rsp_data         (rsp_data),
      .rsp_frame_length (rsp_frame_length),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .results_checked  (results_checked)
   );

   // One input transaction. The sender runs in bursts; a burst may open with
   // a gap, and about half the bursts have none, so push stays high across them.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_push    <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full) begin
         full_stalls++;
         @(posedge clock);
      end
      bytes_sent++;
   endtask

   // Hunting noise: anything but the current sync byte.
   task automatic send_noise(input int count);
      logic [7:0] b;
      repeat (count) begin
         b = 8'($urandom_range(0, 255));
         if (b == cur_sync)
            b = ~b;
         send_byte(b);
      end
   endtask

   task automatic send_header(input logic [7:0] cmd, input logic [15:0] len);
      frames_sent++;
      send_byte(cur_sync);
      tx_crc = frame_crc_pkg::crc8_next(8'h00, cmd);
      tx_crc = frame_crc_pkg::crc8_next(tx_crc, len[7:0]);
      tx_crc = frame_crc_pkg::crc8_next(tx_crc, len[15:8]);
      send_byte(cmd);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
   endtask

   task automatic send_body(input logic [7:0] b);
      tx_crc = frame_crc_pkg::crc8_next(tx_crc, b);
      send_byte(b);
   endtask

   // Whole frame. Past max_payload only one byte follows the header: the
   // block drops it and goes back to hunting.
   task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len, input bit corrupt);
      logic [7:0] b;
      send_header(cmd, len);
      if (len > cur_max) begin
         oversize_frames++;
         b = 8'($urandom_range(0, 255));
         send_byte(b);
      end else begin
         repeat (len) begin
            b = 8'($urandom_range(0, 255));
            send_body(b);
         end
         if (corrupt) begin
            bad_crc_frames++;
            b = 8'($urandom_range(1, 255));
            send_byte(tx_crc ^ b);
         end else begin
            send_byte(tx_crc);
         end
      end
   endtask

   // Stop sending and wait until every queued result has been taken, then let
   // the front end settle for header bytes it still holds.
   task automatic wait_all_results();
      req_push   <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (pending_count != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input crcfr_pkg::csr_index_type idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_max(input logic [15:0] value);
      write_reg(crcfr_pkg::CSR_MAX_PAYLOAD, value);
      cur_max = value;
   endtask

   task automatic set_config(input logic [7:0] sync, input logic [15:0] max_len);
      logic [7:0] junk;
      junk = 8'($urandom_range(0, 255));   // upper write bits are don't-care for sync
      write_reg(crcfr_pkg::CSR_SYNC_BYTE, {junk, sync});
      cur_sync = sync;
      set_max(max_len);
      settings_used++;
   endtask

   // Receiver: switches between stall patterns at random intervals. On a
   // hold request it keeps pop low for HOLD_CYCLES so the queue backs up.
   initial begin : result_sink
      int mode;
      int mode_left;
      int tick;
      mode      = SINK_ALWAYS;
      mode_left = 0;
      tick      = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_request) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            long_holds++;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(SINK_ALWAYS, SINK_SPARSE);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               SINK_ALWAYS:       rsp_pop <= 1'b1;
               SINK_COIN:         rsp_pop <= 1'($urandom_range(0, 1));
               SINK_EVERY_FOURTH: rsp_pop <= (tick % 4 == 0);
               default:           rsp_pop <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // Watchdog: any stretch without a transaction on either channel is a hang.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, pending_count);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int          p;
      int          pick;
      int          phase_start;
      logic [7:0]  cmd_v;
      logic [7:0]  sync_v;
      logic [7:0]  b;
      logic [15:0] len_v;
      logic [15:0] max_v;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed, reset register values ---
      send_byte(8'h00);                     // noise while hunting
      send_byte(8'hFF);
      send_frame(8'h00, 16'd0, 1'b0);       // zero length: CRC right after header
      send_header(8'hFF, 16'd2);            // sync value inside the payload is plain data
      send_body(crcfr_pkg::SYNC_BYTE_RESET);
      send_body(8'h00);
      send_byte(tx_crc ^ 8'h80);
      bad_crc_frames++;
      send_header(8'h5A, 16'd513);          // one past the limit; next byte dropped, not
      send_byte(crcfr_pkg::SYNC_BYTE_RESET); // taken as a new sync
      oversize_frames++;
      send_byte(8'h3C);

      // --- directed, extreme settings and writes in the middle of a frame ---
      wait_all_results();
      set_config(8'h00, 16'd0);
      send_frame(8'h81, 16'd0, 1'b0);
      send_frame(8'h7E, 16'd1, 1'b0);
      send_header(8'h42, 16'd3);            // too long for max 0 ...
      wait_all_results();
      set_max(16'hFFFF);                    // ... until the limit is raised mid-frame
      repeat (3) begin
         b = 8'($urandom_range(0, 255));
         send_body(b);
      end
      send_byte(tx_crc);
      send_header(8'h24, 16'd3);
      wait_all_results();
      set_max(16'd2);                       // lowered mid-frame -> oversize
      send_byte(8'h99);
      oversize_frames++;

      // --- random phases, one register setting each ---
      for (p = 0; p < RANDOM_PHASES; p++) begin
         wait_all_results();
         case (p)
            0: set_config(crcfr_pkg::SYNC_BYTE_RESET, crcfr_pkg::MAX_PAYLOAD_RESET);
            1: set_config(8'h00, 16'd0);
            2: set_config(8'hFF, 16'hFFFF);
            default: begin
               sync_v = 8'($urandom_range(0, 255));
               pick   = $urandom_range(0, 3);
               case (pick)
                  0:       max_v = 16'd1;
                  1:       max_v = 16'($urandom_range(0, 30));
                  2:       max_v = 16'($urandom_range(0, 65535));
                  default: max_v = crcfr_pkg::MAX_PAYLOAD_RESET;
               endcase
               set_config(sync_v, max_v);
            end
         endcase

         if (p == 0) begin
            // receiver holds off while a long frame keeps coming: queue fills,
            // req_full rises and the sender has to wait
            hold_request = 1'b1;
            cmd_v = 8'($urandom_range(0, 255));
            send_frame(cmd_v, 16'd30, 1'b0);
         end

         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_ITEMS) begin
            pick  = $urandom_range(0, 99);
            cmd_v = 8'($urandom_range(0, 255));
            if (pick < 8) begin
               send_noise($urandom_range(1, 6));
            end else if (pick < 14) begin
               // broken frame: payload cut short, no CRC; what follows fills it up
               len_v = 16'($urandom_range(1, 12));
               send_header(cmd_v, len_v);
               if (len_v > cur_max) begin
                  oversize_frames++;
                  b = 8'($urandom_range(0, 255));
                  send_byte(b);
               end else begin
                  repeat ($urandom_range(0, len_v - 1)) begin
                     b = 8'($urandom_range(0, 255));
                     send_body(b);
                  end
               end
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 75 || cur_max == 16'hFFFF)
                  len_v = 16'($urandom_range(0, 24));
               else if (pick < 85)
                  len_v = 16'($urandom_range(25, 300));
               else
                  len_v = 16'($urandom_range(cur_max + 1, 65535));
               send_frame(cmd_v, len_v, $urandom_range(0, 4) == 0);
            end
         end
      end

      wait_all_results();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);

      $display("covered: %0d bytes, %0d frames (%0d oversize, %0d bad CRC), %0d results checked",
               bytes_sent, frames_sent, oversize_frames, bad_crc_frames, results_checked);
      $display("         %0d register settings, %0d long receiver hold-offs, %0d full stalls",
               settings_used, long_holds, full_stalls);
      if (error_count == 0 && pending_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
